// ===== src/ctc_pkg.sv =====
// ============================================================================
// ctc_pkg: shared types, constants and tables of the greedy CTC decoder
// Holds the channel payload structs, the controller/datapath interface
// structs, the register indexes and the exp(-d) table built at elaboration.
// ============================================================================
package ctc_pkg;

  localparam int VOCAB_MAX       = 65536;
  localparam int EXP_TABLE_DEPTH = 1024;
  localparam int EXP_ADDR_W      = $clog2(EXP_TABLE_DEPTH);
  localparam int EXP_W           = 17;
  localparam int IDX_PROD_W      = 12 + $clog2(EXP_TABLE_DEPTH + 1);
  localparam int SUM_W           = 32;
  localparam int PROD_W          = SUM_W + EXP_W;
  localparam int VOCAB_W         = 17;
  localparam int LABEL_W         = 17;
  localparam int QUOT_W          = 16;
  localparam int STEP_W          = $clog2(QUOT_W + 1);

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 17;
  localparam logic [CFG_INDEX_W-1:0] REG_VOCAB_SIZE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLANK_ID   = 1'b1;

  localparam logic [LABEL_W-1:0] LABEL_NONE = '1;
  localparam logic [SUM_W-1:0]   ONE_Q16    = 32'h0001_0000;
  localparam logic [SUM_W-1:0]   SUM_MAX    = '1;
  localparam logic [VOCAB_W-1:0] VOCAB_LIMIT = VOCAB_W'(VOCAB_MAX);

  typedef struct packed {
    logic signed [15:0] logit;
    logic               utterance_start;
  } logit_item_t;

  typedef struct packed {
    logic [15:0] token_id;
    logic [15:0] probability;
    logic [15:0] frame_index;
  } token_item_t;

  typedef struct packed {
    logic accept;
    logic mul;
    logic update;
    logic load_out;
  } ctc_cmd_t;

  typedef struct packed {
    logic emit;
    logic div_done;
  } ctc_status_t;

  typedef logic [EXP_W-1:0] exp_rom_t [EXP_TABLE_DEPTH];

  // Floor of num / den by restoring long division; used only to build the table.
  function automatic logic [63:0] div_small(input logic [63:0] num,
                                            input logic [3:0]  den);
    logic [63:0] q;
    logic [4:0]  r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[3:0], num[i]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-16k/DEPTH) in Q16: ten Taylor terms of exp(-a/32), then squared five times.
  // The table depth is a power of two, so the scaling of k is a shift.
  function automatic logic [EXP_W-1:0] exp_entry(input int unsigned k);
    logic [63:0]        a;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] e;
    if (k == 0) begin
      return EXP_W'(ONE_Q16);
    end
    a    = (64'(k) << 31) >> EXP_ADDR_W;
    term = 64'd1 << 32;
    e    = signed'(term);
    for (int n = 1; n < 10; n++) begin
      term = div_small((term * a) >> 32, 4'(n));
      if ((n & 1) == 1) begin
        e = e - signed'(term);
      end else begin
        e = e + signed'(term);
      end
    end
    v = unsigned'(e);
    for (int s = 0; s < 5; s++) begin
      v = (v * v + (64'd1 << 31)) >> 32;
    end
    return EXP_W'((v + 64'd32768) >> 16);
  endfunction

  function automatic exp_rom_t build_exp_rom();
    exp_rom_t rom;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      rom[k] = exp_entry(k);
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

// ===== src/ctc_greedy_decoder_core.sv =====
// ============================================================================
// ctc_greedy_decoder_core: streaming greedy CTC decoder
// Folds row-major logits into a running maximum and an online softmax sum
// and emits a token with its probability on a new, non-blank frame winner.
// ============================================================================
//
// Channel    Direction  Payload               Handshake
// logit      in         ctc_pkg::logit_item_t logit_valid / logit_stall
// token      out        ctc_pkg::token_item_t token_valid / token_stall
// cfg        in         index + data          cfg_write_en, no wait
//
// Each logit passes through transfer, multiply and state update in turn;
// the exp table ROM read and the rescaling multiplier are each registered.
// A row end that emits a token adds the reciprocal of the denominator:
// the bit-serial divider runs, then the output step loads the result; the
// divider does not iterate when the probability saturates.
// Reset is synchronous and active high; it restores the register defaults
// and the decoder state, and no clearing pass follows it.
// A stalled token does not stop the next logit transfer: the result sits in
// the output register, and only a second token waits for that register.
//
module ctc_greedy_decoder_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             logit_valid,
  output logic                             logit_stall,
  input  ctc_pkg::logit_item_t             logit_item,
  output logic                             token_valid,
  input  logic                             token_stall,
  output ctc_pkg::token_item_t             token_item,
  input  logic                             cfg_write_en,
  input  logic [ctc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ctc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Commands from the state machine and status back from the datapath.
  ctc_pkg::ctc_cmd_t    cmd;
  ctc_pkg::ctc_status_t status;

  ctc_controller u_controller (
    .clk         (clk),
    .rst         (rst),
    .logit_valid (logit_valid),
    .logit_stall (logit_stall),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .status      (status),
    .cmd         (cmd)
  );

  // The datapath owns all arithmetic, the configuration registers and the
  // output payload; the controller owns only sequencing and token_valid.
  ctc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .logit_item   (logit_item),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .token_item   (token_item)
  );

endmodule

// ===== src/ctc_recip.sv =====
// ============================================================================
// ctc_recip: iterative Q0.16 reciprocal of the softmax denominator
// Computes min(65535, floor(2^32 / divisor)), one quotient bit per cycle.
// ============================================================================
module ctc_recip (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [ctc_pkg::SUM_W-1:0]        divisor,
  output logic                             done,
  output logic [ctc_pkg::QUOT_W-1:0]       quotient
);

  logic                          running;
  logic [ctc_pkg::STEP_W-1:0]    step_count;
  logic [ctc_pkg::SUM_W:0]       rem;
  logic [ctc_pkg::SUM_W:0]       rem_shift;
  logic [ctc_pkg::SUM_W:0]       dvs;
  logic [ctc_pkg::SUM_W-1:0]     divisor_reg;
  logic                          saturate;
  logic                          fits;

  // A denominator of one or less in Q16 gives a quotient of at least 65536.
  assign saturate  = divisor <= ctc_pkg::ONE_Q16;
  assign rem_shift = {rem[ctc_pkg::SUM_W-1:0], 1'b0};
  assign dvs       = {1'b0, divisor_reg};
  assign fits      = rem_shift >= dvs;
  assign done      = !running;

  always_ff @(posedge clk) begin
    if (rst) begin
      running    <= 1'b0;
      step_count <= '0;
    end else if (start) begin
      running    <= !saturate;
      step_count <= ctc_pkg::STEP_W'(ctc_pkg::QUOT_W);
    end else if (running) begin
      step_count <= step_count - ctc_pkg::STEP_W'(1);
      if (step_count == ctc_pkg::STEP_W'(1)) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      divisor_reg <= divisor;
      rem         <= (ctc_pkg::SUM_W + 1)'(ctc_pkg::ONE_Q16);
      quotient    <= saturate ? '1 : '0;
    end else if (running) begin
      rem      <= fits ? (rem_shift - dvs) : rem_shift;
      quotient <= {quotient[ctc_pkg::QUOT_W-2:0], fits};
    end
  end

endmodule

// ===== src/ctc_datapath.sv =====
// ============================================================================
// ctc_datapath: running maximum, online softmax sum and emission logic
// Holds the configuration and decoder state, the exp table ROM, the
// rescaling multiplier, the reciprocal unit and the output payload register.
// ============================================================================
module ctc_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  ctc_pkg::ctc_cmd_t                   cmd,
  output ctc_pkg::ctc_status_t                status,
  input  ctc_pkg::logit_item_t                logit_item,
  input  logic                                cfg_write_en,
  input  logic [ctc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ctc_pkg::CFG_DATA_W-1:0]      cfg_data,
  output ctc_pkg::token_item_t                token_item
);

  // Configuration and decoder state.
  logic [ctc_pkg::VOCAB_W-1:0]    vocab_size;
  logic [15:0]                    blank_label;
  logic [ctc_pkg::LABEL_W-1:0]    previous_label;
  logic signed [15:0]             best_value;
  logic [15:0]                    best_index;
  logic [ctc_pkg::SUM_W-1:0]      exp_sum;
  logic [15:0]                    element_count;
  logic [15:0]                    frame_count;

  // Per-item registers.
  logic signed [15:0]             x_reg;
  logic                           start_reg;
  logic                           first_reg;
  logic                           gt_reg;
  logic                           far_reg;
  logic [ctc_pkg::EXP_W-1:0]      rom_data;
  logic [ctc_pkg::PROD_W-1:0]     product;
  logic [15:0]                    emit_label;
  logic [15:0]                    emit_frame;

  // Accept-cycle logic.
  logic [16:0]                    diff;
  logic [16:0]                    neg_diff;
  logic                           gt_now;
  logic [15:0]                    mag;
  logic [ctc_pkg::IDX_PROD_W-1:0] idx_prod;
  logic [ctc_pkg::EXP_ADDR_W-1:0] rom_addr;
  logic                           first_now;

  // Update-cycle logic.
  logic [15:0]                    eff_elem;
  logic [15:0]                    eff_frame;
  logic [ctc_pkg::LABEL_W-1:0]    eff_prev;
  logic [ctc_pkg::EXP_W-1:0]      ev;
  logic [ctc_pkg::SUM_W-1:0]      scaled;
  logic [ctc_pkg::SUM_W-1:0]      add_a;
  logic [ctc_pkg::SUM_W-1:0]      add_b;
  logic [ctc_pkg::SUM_W:0]        add_sum;
  logic [ctc_pkg::SUM_W-1:0]      sum_next;
  logic signed [15:0]             best_value_next;
  logic [15:0]                    best_index_next;
  logic [ctc_pkg::VOCAB_W-1:0]    veff;
  logic                           row_end;
  logic                           new_label;
  logic                           emit;

  logic                           div_done;
  logic [ctc_pkg::QUOT_W-1:0]     quotient;

  // Difference to the current maximum, always as a non-negative magnitude.
  assign diff      = {logit_item.logit[15], logit_item.logit} - {best_value[15], best_value};
  assign neg_diff  = -diff;
  assign gt_now    = !diff[16] && (diff != 17'd0);
  assign mag       = gt_now ? diff[15:0] : neg_diff[15:0];
  assign idx_prod  = ctc_pkg::IDX_PROD_W'(mag[11:0]) *
                     ctc_pkg::IDX_PROD_W'(ctc_pkg::EXP_TABLE_DEPTH);
  assign rom_addr  = idx_prod[12 +: ctc_pkg::EXP_ADDR_W];
  assign first_now = logit_item.utterance_start || (element_count == 16'd0);

  // A distance of 16.0 or more weighs nothing, for a sum term and a rescale alike.
  assign ev = far_reg ? '0 : rom_data;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_reg     <= logit_item.logit;
      start_reg <= logit_item.utterance_start;
      first_reg <= first_now;
      gt_reg    <= gt_now;
      far_reg   <= mag[15:12] != 4'd0;
      rom_data  <= ctc_pkg::EXP_ROM[rom_addr];
    end
    if (cmd.mul) begin
      product <= ctc_pkg::PROD_W'(exp_sum) * ctc_pkg::PROD_W'(ev);
    end
  end

  // The start flag acts before the logit is folded in.
  assign eff_elem  = start_reg ? 16'd0 : element_count;
  assign eff_frame = start_reg ? 16'd0 : frame_count;
  assign eff_prev  = start_reg ? ctc_pkg::LABEL_NONE : previous_label;

  assign scaled = product[ctc_pkg::PROD_W-1] ? ctc_pkg::SUM_MAX :
                  product[16 +: ctc_pkg::SUM_W];

  always_comb begin
    add_a = gt_reg ? scaled : exp_sum;
    add_b = gt_reg ? ctc_pkg::ONE_Q16 : ctc_pkg::SUM_W'(ev);
    add_sum = {1'b0, add_a} + {1'b0, add_b};
    if (first_reg) begin
      sum_next        = ctc_pkg::ONE_Q16;
      best_value_next = x_reg;
      best_index_next = 16'd0;
    end else if (gt_reg) begin
      sum_next        = add_sum[ctc_pkg::SUM_W] ? ctc_pkg::SUM_MAX :
                        add_sum[ctc_pkg::SUM_W-1:0];
      best_value_next = x_reg;
      best_index_next = eff_elem;
    end else begin
      sum_next        = add_sum[ctc_pkg::SUM_W] ? ctc_pkg::SUM_MAX :
                        add_sum[ctc_pkg::SUM_W-1:0];
      best_value_next = best_value;
      best_index_next = best_index;
    end
  end

  always_comb begin
    if (vocab_size == '0) begin
      veff = ctc_pkg::VOCAB_W'(1);
    end else if (vocab_size > ctc_pkg::VOCAB_LIMIT) begin
      veff = ctc_pkg::VOCAB_LIMIT;
    end else begin
      veff = vocab_size;
    end
  end

  assign row_end   = ({1'b0, eff_elem} + 17'd1) >= veff;
  assign new_label = {1'b0, best_index_next} != eff_prev;
  assign emit      = row_end && new_label && (best_index_next != blank_label);

  assign status.emit     = emit;
  assign status.div_done = div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      vocab_size     <= ctc_pkg::VOCAB_LIMIT;
      blank_label    <= 16'd0;
      previous_label <= ctc_pkg::LABEL_NONE;
      best_value     <= 16'sd0;
      best_index     <= 16'd0;
      exp_sum        <= '0;
      element_count  <= 16'd0;
      frame_count    <= 16'd0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          ctc_pkg::REG_VOCAB_SIZE: vocab_size  <= cfg_data;
          ctc_pkg::REG_BLANK_ID:   blank_label <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.update) begin
        best_value <= best_value_next;
        best_index <= best_index_next;
        exp_sum    <= sum_next;
        if (row_end && new_label) begin
          previous_label <= {1'b0, best_index_next};
        end else begin
          previous_label <= eff_prev;
        end
        if (row_end && (eff_frame != 16'hFFFF)) begin
          frame_count <= eff_frame + 16'd1;
        end else begin
          frame_count <= eff_frame;
        end
        if (row_end) begin
          element_count <= 16'd0;
        end else begin
          element_count <= eff_elem + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && emit) begin
      emit_label <= best_index_next;
      emit_frame <= eff_frame;
    end
    if (cmd.load_out) begin
      token_item.token_id    <= emit_label;
      token_item.probability <= quotient;
      token_item.frame_index <= emit_frame;
    end
  end

  ctc_recip u_recip (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.update && emit),
    .divisor  (sum_next),
    .done     (div_done),
    .quotient (quotient)
  );

endmodule

// ===== src/ctc_controller.sv =====
// ============================================================================
// ctc_controller: sequencing state machine of the greedy CTC decoder
// Steps each logit through multiply and update, waits on the reciprocal
// unit for an emission and owns the output valid flag.
// ============================================================================
module ctc_controller (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  logit_valid,
  output logic                  logit_stall,
  output logic                  token_valid,
  input  logic                  token_stall,
  input  ctc_pkg::ctc_status_t  status,
  output ctc_pkg::ctc_cmd_t     cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign out_free     = !token_valid || !token_stall;
  assign logit_stall  = state != S_IDLE;
  assign cmd.accept   = (state == S_IDLE) && logit_valid;
  assign cmd.mul      = state == S_MUL;
  assign cmd.update   = state == S_UPD;
  assign cmd.load_out = (state == S_OUT) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (logit_valid) state_next = S_MUL;
      S_MUL:  state_next = S_UPD;
      S_UPD:  state_next = status.emit ? S_DIV : S_IDLE;
      S_DIV:  if (status.div_done) state_next = S_OUT;
      S_OUT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      token_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        token_valid <= 1'b1;
      end else if (!token_stall) begin
        token_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/ctc_checker.sv =====
// ============================================================================
// ctc_checker: port-level assertions for the greedy CTC decoder
// Watches the logit and token channels of the top level and is bound to it below.
// ============================================================================
module ctc_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  logit_valid,
  input logic                  logit_stall,
  input logic                  token_valid,
  input logic                  token_stall,
  input ctc_pkg::token_item_t  token_item
);

  // A stalled token stays offered and unchanged.
  a_token_hold: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_stall |=> token_valid && $stable(token_item))
    else $error("token changed while stalled");

  // A logit transfer is always followed by a stall, so logits never go in back to back.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    logit_valid && !logit_stall |=> logit_stall)
    else $error("logit taken on consecutive cycles");

  // A new token appears only out of the output step, when input is held off.
  a_token_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(token_valid) |-> $past(logit_stall))
    else $error("token appeared while the block was idle");

  // The denominator never exceeds 2^32 - 1, so the probability is never zero.
  a_prob_nonzero: assert property (@(posedge clk) disable iff (rst)
    token_valid |-> token_item.probability != 16'd0)
    else $error("zero probability on an emitted token");

endmodule

bind ctc_greedy_decoder_core ctc_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .logit_valid (logit_valid),
  .logit_stall (logit_stall),
  .token_valid (token_valid),
  .token_stall (token_stall),
  .token_item  (token_item)
);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Greedy CTC decoder testbench
// Streams logit rows into ctc_greedy_decoder_core under random idling on both
// channels, predicts every token with its own fixed point decoder and checks
// each token transfer, field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LUT_DEPTH      = ctc_pkg::EXP_TABLE_DEPTH;
  localparam int VOCAB_CAP      = ctc_pkg::VOCAB_MAX;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTS     = 100;
  localparam logic [16:0] NO_LABEL = '1;
  localparam logic [31:0] ONE_Q16  = 32'h0001_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                   logit_valid = 1'b0;
  logic                                   logit_stall;
  ctc_pkg::logit_item_t                   logit_item = '0;
  logic                                   token_valid;
  logic                                   token_stall = 1'b0;
  ctc_pkg::token_item_t                   token_item;
  logic                                   cfg_write_en = 1'b0;
  logic [ctc_pkg::CFG_INDEX_W-1:0]        cfg_index = '0;
  logic [ctc_pkg::CFG_DATA_W-1:0]         cfg_data = '0;

  ctc_greedy_decoder_core dut (
    .clk          (clk),
    .rst          (rst),
    .logit_valid  (logit_valid),
    .logit_stall  (logit_stall),
    .logit_item   (logit_item),
    .token_valid  (token_valid),
    .token_stall  (token_stall),
    .token_item   (token_item),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Decoder mirror: registers and per-row state, at their reset values.
  logic [16:0]        model_vocab = 17'd65536;
  logic [15:0]        model_blank = '0;
  logic [16:0]        last_label  = NO_LABEL;
  logic signed [15:0] row_max     = '0;
  logic [15:0]        row_argmax  = '0;
  logic [31:0]        row_sum     = '0;
  logic [15:0]        col         = '0;
  logic [15:0]        frame_no    = '0;

  logic [16:0]          exp_lut [LUT_DEPTH];
  ctc_pkg::token_item_t pending_tokens [$];

  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left  = 0;
  bit          gaps_on     = 1'b0;
  bit          stalls_on   = 1'b0;
  bit          sender_busy = 1'b0;

  // exp(-16k/DEPTH) in Q16: a Taylor series of exp(-x/32), squared five times.
  initial begin : exp_lut_init
    logic [63:0] arg;
    logic [63:0] term;
    logic [63:0] v;
    longint      e;
    exp_lut[0] = 17'd65536;
    for (int k = 1; k < LUT_DEPTH; k++) begin
      arg  = (64'(k) << 31) / 64'(LUT_DEPTH);
      term = 64'd1 << 32;
      e    = longint'(term);
      for (int n = 1; n < 10; n++) begin
        term = (term * arg) / (64'(n) << 32);
        e    = ((n % 2) == 1) ? e - longint'(term) : e + longint'(term);
      end
      v = 64'(e);
      repeat (5) v = (v * v + (64'd1 << 31)) >> 32;
      exp_lut[k] = 17'((v + 64'd32768) >> 16);
    end
  end

  // exp(-d) for a non-negative Q8.8 distance below the running maximum.
  function automatic logic [16:0] exp_of_gap(input logic [31:0] d);
    logic [31:0] slot;
    if (d >= 32'd4096) begin
      return '0;
    end
    slot = (d * LUT_DEPTH) >> 12;
    return (slot < LUT_DEPTH) ? exp_lut[slot] : '0;
  endfunction

  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

  // Folds one logit into the row; returns 1 with the token when the row ends
  // on a new, non-blank winner.
  function automatic bit decode_logit(input ctc_pkg::logit_item_t it,
                                      output ctc_pkg::token_item_t tok);
    logic signed [15:0] x;
    logic [31:0]        row_len;
    logic [63:0]        scaled;
    logic [63:0]        quot;
    bit                 emit;
    x    = it.logit;
    emit = 1'b0;
    tok  = '0;
    row_len = (model_vocab == '0) ? 32'd1 :
              (model_vocab > VOCAB_CAP) ? 32'(VOCAB_CAP) : 32'(model_vocab);
    if (it.utterance_start) begin
      last_label = NO_LABEL;
      frame_no   = '0;
      col        = '0;
    end
    if (col == '0) begin
      row_max    = x;
      row_argmax = '0;
      row_sum    = ONE_Q16;
    end else if (x > row_max) begin
      // A new maximum rescales everything summed so far by exp(old - new).
      scaled  = (64'(row_sum) * 64'(exp_of_gap(32'(int'(x) - int'(row_max))))) >> 16;
      row_sum = add_sat((scaled > 64'hFFFF_FFFF) ? '1 : scaled[31:0], ONE_Q16);
      row_max    = x;
      row_argmax = col;
    end else begin
      row_sum = add_sat(row_sum, 32'(exp_of_gap(32'(int'(row_max) - int'(x)))));
    end
    if (32'(col) + 32'd1 >= row_len) begin
      col = '0;
      if ({1'b0, row_argmax} != last_label) begin
        last_label = {1'b0, row_argmax};
        if (row_argmax != model_blank) begin
          quot = 64'h1_0000_0000 / 64'((row_sum == '0) ? 32'd1 : row_sum);
          tok.token_id    = row_argmax;
          tok.probability = (quot > 64'd65535) ? 16'hFFFF : quot[15:0];
          tok.frame_index = frame_no;
          emit = 1'b1;
        end
      end
      if (frame_no != 16'hFFFF) begin
        frame_no = frame_no + 16'd1;
      end
    end else begin
      col = col + 16'd1;
    end
    return emit;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(3, 1);
    end else if (r < 97) begin
      return $urandom_range(10, 4);
    end
    return $urandom_range(40, 15);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    error_count++;
    if (error_count <= MAX_PRINTS) begin
      $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  task automatic lower_valid();
    if (sender_busy) begin
      logit_valid <= 1'b0;
      sender_busy = 1'b0;
    end
  endtask

  // One logit transfer; the token it causes, if any, joins the pending list.
  task automatic send_logit(input logic signed [15:0] value, input bit start);
    ctc_pkg::token_item_t tok;
    int unsigned          gap;
    logit_item <= '{logit: value, utterance_start: start};
    if (!sender_busy) begin
      logit_valid <= 1'b1;
      sender_busy = 1'b1;
    end
    do @(posedge clk); while (logit_stall !== 1'b0);
    if (decode_logit(logit_item, tok)) begin
      pending_tokens.insert(pending_tokens.size(), tok);
    end
    gap = gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      lower_valid();
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the sender until every token is out, then lets a row end that emits
  // nothing finish inside the block.
  task automatic wait_idle();
    lower_valid();
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ctc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [ctc_pkg::CFG_DATA_W-1:0] value);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (idx == ctc_pkg::REG_VOCAB_SIZE) begin
      model_vocab = value;
    end else begin
      model_blank = value[15:0];
    end
    @(posedge clk);
  endtask

  // Token side: checks each transfer against the oldest prediction and keeps
  // a random stall pattern going.
  always @(posedge clk) begin : token_monitor
    ctc_pkg::token_item_t want;
    if (!rst) begin
      if (token_valid === 1'b1 && token_stall == 1'b0) begin
        if (pending_tokens.size() == 0) begin
          report_mismatch("token with none predicted, token_id", 0, token_item.token_id);
        end else begin
          want = pending_tokens.pop_front();
          if (token_item.token_id !== want.token_id) begin
            report_mismatch("token_id", want.token_id, token_item.token_id);
          end
          if (token_item.probability !== want.probability) begin
            report_mismatch("probability", want.probability, token_item.probability);
          end
          if (token_item.frame_index !== want.frame_index) begin
            report_mismatch("frame_index", want.frame_index, token_item.frame_index);
          end
        end
      end
      if (stall_left != 0) begin
        token_stall <= 1'b1;
        stall_left--;
      end else begin
        token_stall <= 1'b0;
        if (stalls_on && $urandom_range(2) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // Ends the run when neither channel nor the register port has moved for
  // too long.
  always @(posedge clk) begin : watchdog
    if (rst || cfg_write_en || (logit_valid && !logit_stall) ||
        (token_valid && !token_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d tokens pending",
               WATCHDOG_LIMIT, pending_tokens.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic test_directed_rows();
    shortint row_vals [26];
    bit      row_starts [26];
    // Rows of four with blank label 3: extremes and a tie on the maximum,
    // the reverse, a blank winner, an all-tied row, a repeated label, and a
    // short row cut off by a new utterance.
    row_vals = '{-32768, 32767, 0, 32767,
                 32767, -32768, 5, 5,
                 10, 20, 30, 40,
                 7, 7, 7, 7,
                 64, 0, 64, -64,
                 -5, 100,
                 200, 180, 220, 150};
    row_starts = '{default: 1'b0};
    row_starts[0]  = 1'b1;
    row_starts[22] = 1'b1;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    write_reg(ctc_pkg::REG_VOCAB_SIZE, 17'd4);
    write_reg(ctc_pkg::REG_BLANK_ID, 17'd3);
    foreach (row_vals[i]) begin
      send_logit(row_vals[i], row_starts[i]);
    end
    wait_idle();
    // A vocabulary of zero behaves as one; a blank above every label never hits.
    write_reg(ctc_pkg::REG_VOCAB_SIZE, 17'd0);
    write_reg(ctc_pkg::REG_BLANK_ID, 17'd65535);
    send_logit(16'sh1234, 1'b1);
    send_logit(-16'sh0400, 1'b0);
    send_logit(16'sh7FFF, 1'b0);
    send_logit(16'sh0000, 1'b1);
    wait_idle();
  endtask

  // A vocabulary above the limit, then shrunk below the position already
  // reached in the row: the next logit closes the row.
  task automatic test_vocab_limits();
    write_reg(ctc_pkg::REG_VOCAB_SIZE, 17'h1FFFF);
    write_reg(ctc_pkg::REG_BLANK_ID, 17'd2);
    for (int k = 0; k < 20; k++) begin
      send_logit(16'(k * 16 - 100), k == 0);
    end
    wait_idle();
    write_reg(ctc_pkg::REG_VOCAB_SIZE, 17'd3);
    send_logit(16'sh0200, 1'b0);
    send_logit(16'sh0010, 1'b0);
    send_logit(16'sh0011, 1'b0);
    send_logit(16'sh0011, 1'b0);
    wait_idle();
  endtask

  // Phases of random settings, each carrying whole utterances of rows whose
  // winner is steered, so that new labels, repeats and blanks all occur.
  task automatic test_random_utterances(input int unsigned budget);
    int unsigned        sent;
    int unsigned        r;
    int unsigned        eff;
    int unsigned        hot;
    int unsigned        last_hot;
    int unsigned        style;
    int                 base;
    int                 peak;
    logic [16:0]        vocab;
    logic [15:0]        blank;
    logic signed [15:0] v;
    bit                 start;
    sent     = 0;
    last_hot = 0;
    while (sent < budget) begin
      wait_idle();
      r = $urandom_range(99);
      if (r < 70) begin
        vocab = 17'($urandom_range(6, 2));
      end else if (r < 86) begin
        vocab = 17'($urandom_range(24, 7));
      end else if (r < 93) begin
        vocab = 17'd1;
      end else begin
        vocab = 17'd0;
      end
      eff = (vocab == '0) ? 1 : int'(vocab);
      r = $urandom_range(99);
      if (r < 50) begin
        blank = 16'($urandom_range(eff - 1));
      end else if (r < 70) begin
        blank = 16'd0;
      end else if (r < 85) begin
        blank = 16'hFFFF;
      end else begin
        blank = 16'($urandom);
      end
      write_reg(ctc_pkg::REG_VOCAB_SIZE, vocab);
      write_reg(ctc_pkg::REG_BLANK_ID, {1'b0, blank});
      // Some phases run with no idling on one side or the other.
      gaps_on   = ($urandom_range(4) != 0);
      stalls_on = ($urandom_range(4) != 0);
      repeat ($urandom_range(4, 1)) begin
        for (int row = 0; row < int'($urandom_range(12, 1)) && sent < budget; row++) begin
          hot   = ($urandom_range(2) == 0) ? (last_hot % eff) : $urandom_range(eff - 1);
          style = $urandom_range(3);
          base  = int'($urandom_range(60000)) - 30000;
          peak  = int'($urandom_range(65535)) - 32768;
          last_hot = hot;
          for (int c = 0; c < int'(eff); c++) begin
            case (style)
              0: v = 16'($urandom);
              // Close scores, so every distance stays below 16.0 and is read from the exp table.
              1: v = (c == int'(hot)) ? 16'(base + int'($urandom_range(1200, 600))) :
                                        16'(base + int'($urandom_range(600)));
              // Ties with the peak elsewhere in the row.
              2: begin
                if (c == int'(hot) || $urandom_range(2) == 0) begin
                  v = 16'(peak);
                end else begin
                  v = 16'((peak - int'($urandom_range(3000, 1)) < -32768) ? -32768 :
                          peak - int'($urandom_range(3000, 1)));
                end
              end
              default: v = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            endcase
            start = (row == 0 && c == 0);
            // A stray start flag now and then breaks a row in the middle.
            if (!start && $urandom_range(199) == 0) begin
              start = 1'b1;
            end
            send_logit(v, start);
            sent++;
          end
        end
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_rows();
    test_vocab_limits();
    test_random_utterances(1850);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ctc_pkg.sv
src/ctc_recip.sv
src/ctc_datapath.sv
src/ctc_controller.sv
src/ctc_greedy_decoder_core.sv
src/ctc_checker.sv
bench/testbench.sv
